// ===== design/tsp_pkg.sv =====
// Shared widths and types for the triangle sides, perimeter and area block.
// Used by the top level and the checker; depends on nothing.
package tsp_pkg;

  localparam int COORD_W = 16;
  localparam int SIDE_W  = 17;
  localparam int PERIM_W = 19;
  localparam int AREA_W  = 28;

  // Area saturation value, all ones at the output width.
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  // Values that ride alongside the area computation.
  typedef struct packed {
    logic [SIDE_W-1:0]  sa;
    logic [SIDE_W-1:0]  sb;
    logic [SIDE_W-1:0]  sc;
    logic [PERIM_W-1:0] p;
    logic               degen;
  } tsp_side_t;

endpackage

// ===== design/tsp_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Handles several lanes in lock step; no package dependency.
module tsp_sqrt #(
  parameter int LANES = 3,
  parameter int DW    = 34
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [LANES-1:0][DW-1:0]         rad_in,
  output logic                             out_valid,
  output logic [LANES-1:0][DW/2-1:0]       root_out
);

  localparam int N  = DW / 2;
  localparam int RW = N + 2;

  logic [N-1:0]  stg_valid;
  logic [DW-1:0] rad_q  [N][LANES];
  logic [RW-1:0] rem_q  [N][LANES];
  logic [N-1:0]  root_q [N][LANES];

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      stg_valid <= {stg_valid[N-2:0], in_valid};
    end
  end

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar k = 0; k < N; k++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW-1:0] src_rad;
      logic [RW-1:0] src_rem;
      logic [N-1:0]  src_root;
      logic [RW-1:0] shifted;
      logic [RW-1:0] trial;
      logic          ge;

      if (k == 0) begin : g_first
        assign src_rad  = rad_in[l];
        assign src_rem  = '0;
        assign src_root = '0;
      end else begin : g_next
        assign src_rad  = rad_q[k-1][l];
        assign src_rem  = rem_q[k-1][l];
        assign src_root = root_q[k-1][l];
      end

      assign shifted = {src_rem[RW-3:0], src_rad[DW-1:DW-2]};
      assign trial   = {src_root, 2'b01};
      assign ge      = (shifted >= trial);

      always_ff @(posedge clk) begin
        rad_q[k][l]  <= {src_rad[DW-3:0], 2'b00};
        rem_q[k][l]  <= ge ? (shifted - trial) : shifted;
        root_q[k][l] <= {src_root[N-2:0], ge};
      end

      assign root_out[l] = root_q[N-1][l];
    end
  end

  assign out_valid = stg_valid[N-1];

endmodule

// ===== design/triangle_sides_perimeter_area.sv =====
// Triangle sides, perimeter and Heron area as a fully pipelined datapath.
// One word can be accepted every cycle, so busy stays low. The two square
// roots take 17 and 38 stages (one root bit each) besides the input,
// difference, square, sum, perimeter, factor and multiply stages.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module triangle_sides_perimeter_area (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [tsp_pkg::COORD_W-1:0] vert_a_x,
  input  logic signed [tsp_pkg::COORD_W-1:0] vert_a_y,
  input  logic signed [tsp_pkg::COORD_W-1:0] vert_b_x,
  input  logic signed [tsp_pkg::COORD_W-1:0] vert_b_y,
  input  logic signed [tsp_pkg::COORD_W-1:0] vert_c_x,
  input  logic signed [tsp_pkg::COORD_W-1:0] vert_c_y,
  output logic                            done,
  output logic [tsp_pkg::SIDE_W-1:0]      side_opp_a,
  output logic [tsp_pkg::SIDE_W-1:0]      side_opp_b,
  output logic [tsp_pkg::SIDE_W-1:0]      side_opp_c,
  output logic [tsp_pkg::PERIM_W-1:0]     perim,
  output logic [tsp_pkg::AREA_W-1:0]      tri_area,
  output logic                            degenerate
);
  import tsp_pkg::*;

  localparam int SQ1_DW = 34;
  localparam int SQ2_DW = 76;
  localparam int SQ2_N  = SQ2_DW / 2;
  localparam int HALF   = 19;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Valid bits for the fixed stages.
  logic v0, v1, v2, v3, v4, v5, v6, v7, v8;
  logic sq1_valid, sq2_valid;

  // Stage 0: input word register.
  logic [COORD_W-1:0] ax, ay, bx, by, cx, cy;
  always_ff @(posedge clk) begin
    ax <= vert_a_x;
    ay <= vert_a_y;
    bx <= vert_b_x;
    by <= vert_b_y;
    cx <= vert_c_x;
    cy <= vert_c_y;
  end

  // Absolute difference of two signed coordinates; fits 16 bits unsigned.
  function automatic logic [COORD_W-1:0] abs_diff(logic [COORD_W-1:0] p0,
                                                  logic [COORD_W-1:0] p1);
    logic [COORD_W:0] d;
    logic [COORD_W:0] n;
    d = {p0[COORD_W-1], p0} - {p1[COORD_W-1], p1};
    n = -d;
    return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

  // Stage 1: differences. Order: a uses B-C, b uses A-C, c uses A-B.
  logic [COORD_W-1:0] dx [3];
  logic [COORD_W-1:0] dy [3];
  always_ff @(posedge clk) begin
    dx[0] <= abs_diff(bx, cx);
    dy[0] <= abs_diff(by, cy);
    dx[1] <= abs_diff(ax, cx);
    dy[1] <= abs_diff(ay, cy);
    dx[2] <= abs_diff(ax, bx);
    dy[2] <= abs_diff(ay, by);
  end

  // Stage 2: squares.
  logic [2*COORD_W-1:0] sqx [3];
  logic [2*COORD_W-1:0] sqy [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sqx[i] <= dx[i] * dx[i];
      sqy[i] <= dy[i] * dy[i];
    end
  end

  // Stage 3: sums of squares, padded to an even width for the root.
  logic [2:0][SQ1_DW-1:0] ssum;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ssum[i] <= {2'b00, sqx[i]} + {2'b00, sqy[i]};
    end
  end

  // Side lengths from a three-lane root pipeline.
  logic [2:0][SQ1_DW/2-1:0] side_root;
  tsp_sqrt #(.LANES(3), .DW(SQ1_DW)) u_side_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .rad_in   (ssum),
    .out_valid(sq1_valid),
    .root_out (side_root)
  );

  // Stage 4: perimeter and triangle inequality.
  tsp_side_t sd4;
  always_ff @(posedge clk) begin
    sd4.sa    <= side_root[0];
    sd4.sb    <= side_root[1];
    sd4.sc    <= side_root[2];
    sd4.p     <= PERIM_W'({2'b00, side_root[0]} + {2'b00, side_root[1]}
                 + {2'b00, side_root[2]});
    sd4.degen <= ({1'b0, side_root[0]} >= {1'b0, side_root[1]} + {1'b0, side_root[2]})
              || ({1'b0, side_root[1]} >= {1'b0, side_root[0]} + {1'b0, side_root[2]})
              || ({1'b0, side_root[2]} >= {1'b0, side_root[0]} + {1'b0, side_root[1]});
  end

  // Stage 5: Heron factors P - 2x, with a flag for all of them positive.
  logic [PERIM_W:0] fa_w, fb_w, fc_w;
  assign fa_w = {1'b0, sd4.p} - {2'b00, sd4.sa, 1'b0};
  assign fb_w = {1'b0, sd4.p} - {2'b00, sd4.sb, 1'b0};
  assign fc_w = {1'b0, sd4.p} - {2'b00, sd4.sc, 1'b0};

  tsp_side_t sd5;
  logic [PERIM_W-1:0] fa5, fb5, fc5;
  logic pos5;
  always_ff @(posedge clk) begin
    sd5  <= sd4;
    fa5  <= fa_w[PERIM_W-1:0];
    fb5  <= fb_w[PERIM_W-1:0];
    fc5  <= fc_w[PERIM_W-1:0];
    pos5 <= !fa_w[PERIM_W] && (fa_w != '0) && !fb_w[PERIM_W] && (fb_w != '0)
         && !fc_w[PERIM_W] && (fc_w != '0);
  end

  // Stage 6: two pair products.
  tsp_side_t sd6;
  logic [2*HALF-1:0] u6, w6;
  logic pos6;
  always_ff @(posedge clk) begin
    sd6  <= sd5;
    u6   <= sd5.p * fa5;
    w6   <= fb5 * fc5;
    pos6 <= pos5;
  end

  // Stage 7: partial products of the wide multiply.
  tsp_side_t sd7;
  logic [2*HALF-1:0] pp_hh, pp_hl, pp_lh, pp_ll;
  logic pos7;
  always_ff @(posedge clk) begin
    sd7   <= sd6;
    pp_hh <= u6[2*HALF-1:HALF] * w6[2*HALF-1:HALF];
    pp_hl <= u6[2*HALF-1:HALF] * w6[HALF-1:0];
    pp_lh <= u6[HALF-1:0] * w6[2*HALF-1:HALF];
    pp_ll <= u6[HALF-1:0] * w6[HALF-1:0];
    pos7  <= pos6;
  end

  // Stage 8: full product, forced to zero when a factor is not positive.
  tsp_side_t sd8;
  logic [0:0][SQ2_DW-1:0] prod8;
  logic [SQ2_DW-1:0] prod_w;
  assign prod_w = {pp_hh, {2*HALF{1'b0}}}
                + {{HALF{1'b0}}, pp_hl, {HALF{1'b0}}}
                + {{HALF{1'b0}}, pp_lh, {HALF{1'b0}}}
                + {{2*HALF{1'b0}}, pp_ll};
  always_ff @(posedge clk) begin
    sd8      <= sd7;
    prod8[0] <= pos7 ? prod_w : '0;
  end

  // Area root pipeline.
  logic [0:0][SQ2_N-1:0] area_root;
  tsp_sqrt #(.LANES(1), .DW(SQ2_DW)) u_area_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v8),
    .rad_in   (prod8),
    .out_valid(sq2_valid),
    .root_out (area_root)
  );

  // Side values wait alongside the area root.
  tsp_side_t sd_line [SQ2_N];
  always_ff @(posedge clk) begin
    sd_line[0] <= sd8;
    for (int k = 1; k < SQ2_N; k++) begin
      sd_line[k] <= sd_line[k-1];
    end
  end

  // Valid bits of the fixed stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
      done <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0; v2 <= v1; v3 <= v2;
      v4 <= sq1_valid; v5 <= v4; v6 <= v5; v7 <= v6; v8 <= v7;
      done <= sq2_valid;
    end
  end

  // Output word: scale the root by 1/64 and saturate.
  always_ff @(posedge clk) begin
    side_opp_a <= sd_line[SQ2_N-1].sa;
    side_opp_b <= sd_line[SQ2_N-1].sb;
    side_opp_c <= sd_line[SQ2_N-1].sc;
    perim      <= sd_line[SQ2_N-1].p;
    degenerate <= sd_line[SQ2_N-1].degen;
    if (area_root[0][SQ2_N-1:AREA_W+6] != '0) begin
      tri_area <= AREA_MAX;
    end else begin
      tri_area <= area_root[0][AREA_W+5:6];
    end
  end

endmodule

// ===== design/tsp_checker.sv =====
// Port-level checks for the triangle block, bound to the top level.
// Depends on tsp_pkg for widths.
module tsp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [tsp_pkg::SIDE_W-1:0]   side_opp_a,
  input logic [tsp_pkg::SIDE_W-1:0]   side_opp_b,
  input logic [tsp_pkg::SIDE_W-1:0]   side_opp_c,
  input logic [tsp_pkg::PERIM_W-1:0]  perim,
  input logic [tsp_pkg::AREA_W-1:0]   tri_area,
  input logic                         degenerate
);
  import tsp_pkg::*;

  // A result word always traces back to a start a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 65))
    else $error("result word without matching start");

  // A degenerate triangle has no area.
  a_degen_area: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (tri_area == '0))
    else $error("degenerate triangle with nonzero area");

  // The perimeter is the sum of the reported sides.
  a_perim: assert property (@(posedge clk) disable iff (rst)
    done |-> ({2'b00, side_opp_a} + {2'b00, side_opp_b} + {2'b00, side_opp_c}
              == {1'b0, perim}))
    else $error("perimeter differs from side sum");

  // The pipeline never pushes back.
  a_no_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("busy raised");

endmodule

bind triangle_sides_perimeter_area tsp_checker u_tsp_checker (.*);
